/* rtl/core/dgto_pkg.sv */
package dgto_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned EdgeW    = 13;

  localparam logic [1:0] OpAdd     = 2'd0;
  localparam logic [1:0] OpConnect = 2'd1;
  localparam logic [1:0] OpOrder   = 2'd2;
  localparam logic [1:0] OpNone    = 2'd3;

  typedef struct packed {
    logic [1:0]      operation;
    logic [IdxW-1:0] from_node;
    logic [IdxW-1:0] to_node;
  } cmd_t;

  typedef struct packed {
    logic             ok;
    logic [IdxW-1:0]  node_id;
    logic             node_valid;
    logic             last;
    logic             has_cycle;
    logic [CntW-1:0]  node_total;
    logic [EdgeW-1:0] edge_total;
  } res_t;

endpackage

/* rtl/core/dgto_ram.sv */
// One-write, one-read synchronous RAM with registered read data.
module dgto_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/dependency_graph_topo_order_unit.sv */
// Dependency graph with topological ordering. Add writes the new node, and
// connect reads the adjacency row and the in-degree together, then writes
// both back. Order first copies the in-degree of all 64 entries into the
// working count (a read and a write per entry, whatever the node count), then
// for each ordered node picks it and reads its adjacency row, does a
// read/modify/write of the working count for each set bit of that row, and
// ends with the final result. Results appear one per strobe and cannot be
// stalled. After reset a clearing pass over all 64 entries zeroes the
// adjacency and in-degree stores; busy is high meanwhile.
module dependency_graph_topo_order_unit
  import dgto_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic valid_o,
  output res_t res_o
);

  localparam logic [3:0] StClr   = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StAddW  = 4'd2;
  localparam logic [3:0] StConR  = 4'd3;
  localparam logic [3:0] StConW  = 4'd4;
  localparam logic [3:0] StCpyR  = 4'd5;
  localparam logic [3:0] StCpyW  = 4'd6;
  localparam logic [3:0] StPick  = 4'd7;
  localparam logic [3:0] StRowR  = 4'd8;
  localparam logic [3:0] StRowW  = 4'd9;
  localparam logic [3:0] StScan  = 4'd10;
  localparam logic [3:0] StDecW  = 4'd11;
  localparam logic [3:0] StFin   = 4'd12;

  logic [3:0]         st_q, st_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [IdxW-1:0]    from_q, from_d, to_q, to_d;
  logic [CntW-1:0]    ncnt_q, ncnt_d;
  logic [EdgeW-1:0]   ecnt_q, ecnt_d;
  logic [MaxNodes-1:0] ready_q, ready_d, row_q, row_d;
  logic [CntW-1:0]    done_q, done_d;
  logic               prev_v_q, prev_v_d;
  logic [IdxW-1:0]    prev_q, prev_d, cur_q, cur_d;
  logic               valid_d;
  res_t               res_d;

  // adjacency RAM
  logic                adj_we;
  logic [IdxW-1:0]     adj_wa, adj_ra;
  logic [MaxNodes-1:0] adj_wd, adj_rd;
  // in-degree RAM: {in-degree, working in-degree} per node
  logic                deg_we;
  logic [IdxW-1:0]     deg_wa, deg_ra;
  logic [2*CntW-1:0]   deg_wd, deg_rd;
  logic [CntW-1:0]     deg_cnt, wrk_cnt;

  dgto_ram #(.Width(MaxNodes), .Depth(MaxNodes), .AddrW(IdxW)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_wa), .wdata_i(adj_wd),
    .raddr_i(adj_ra), .rdata_o(adj_rd)
  );
  dgto_ram #(.Width(2*CntW), .Depth(MaxNodes), .AddrW(IdxW)) u_deg (
    .clk_i, .we_i(deg_we), .waddr_i(deg_wa), .wdata_i(deg_wd),
    .raddr_i(deg_ra), .rdata_o(deg_rd)
  );

  assign deg_cnt = deg_rd[2*CntW-1:CntW];
  assign wrk_cnt = deg_rd[CntW-1:0];

  // lowest set bit of a 64-bit vector
  function automatic logic [IdxW-1:0] low_bit(input logic [MaxNodes-1:0] v);
    logic [IdxW-1:0] r;
    r = '0;
    for (int i = MaxNodes - 1; i >= 0; i--) begin
      if (v[i]) r = IdxW'(i);
    end
    return r;
  endfunction

  assign busy = (st_q != StIdle);

  // control sequencer
  always_comb begin
    logic [IdxW-1:0] nx;
    logic [CntW-1:0] dec;
    st_d = st_q; idx_d = idx_q; from_d = from_q; to_d = to_q;
    ncnt_d = ncnt_q; ecnt_d = ecnt_q; ready_d = ready_q; row_d = row_q;
    done_d = done_q; prev_v_d = prev_v_q; prev_d = prev_q; cur_d = cur_q;
    valid_d = 1'b0;
    res_d = '0;
    adj_we = 1'b0; adj_wa = idx_q; adj_wd = '0; adj_ra = from_q;
    deg_we = 1'b0; deg_wa = idx_q; deg_wd = '0; deg_ra = to_q;
    nx = low_bit(row_q);
    dec = wrk_cnt - CntW'(1);
    unique case (st_q)
      StClr: begin
        adj_we = 1'b1; deg_we = 1'b1;
        idx_d = idx_q + IdxW'(1);
        if (idx_q == IdxW'(MaxNodes - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (start) begin
          from_d = cmd_i.from_node; to_d = cmd_i.to_node;
          unique case (cmd_i.operation)
            OpAdd:     st_d = StAddW;
            OpConnect: st_d = StConR;
            OpOrder: begin
              st_d = StCpyR; idx_d = '0; ready_d = '0;
              done_d = '0; prev_v_d = 1'b0;
            end
            default: st_d = StIdle;
          endcase
        end
      end
      StAddW: begin
        valid_d = 1'b1; res_d.last = 1'b1;
        if (ncnt_q >= CntW'(MaxNodes)) begin
          res_d.node_total = ncnt_q;
        end else begin
          adj_we = 1'b1; deg_we = 1'b1;
          adj_wa = ncnt_q[IdxW-1:0]; deg_wa = ncnt_q[IdxW-1:0];
          ncnt_d = ncnt_q + CntW'(1);
          res_d.ok = 1'b1; res_d.node_valid = 1'b1;
          res_d.node_id = ncnt_q[IdxW-1:0];
          res_d.node_total = ncnt_d;
        end
        res_d.edge_total = ecnt_q;
        st_d = StIdle;
      end
      StConR: begin
        // adj_ra/deg_ra already present from/to
        st_d = StConW;
      end
      StConW: begin
        valid_d = 1'b1; res_d.last = 1'b1;
        if (CntW'(from_q) >= ncnt_q || CntW'(to_q) >= ncnt_q) begin
          res_d.ok = 1'b0;
        end else begin
          res_d.ok = 1'b1;
          if (!adj_rd[to_q]) begin
            adj_we = 1'b1; adj_wa = from_q;
            adj_wd = adj_rd | (MaxNodes'(1) << to_q);
            deg_we = 1'b1; deg_wa = to_q;
            deg_wd = {deg_cnt + CntW'(1), wrk_cnt};
            ecnt_d = ecnt_q + EdgeW'(1);
          end
        end
        res_d.node_total = ncnt_q; res_d.edge_total = ecnt_d;
        st_d = StIdle;
      end
      StCpyR: begin
        deg_ra = idx_q; st_d = StCpyW;
      end
      StCpyW: begin
        deg_we = 1'b1; deg_wa = idx_q; deg_wd = {deg_cnt, deg_cnt};
        if (CntW'(idx_q) < ncnt_q && deg_cnt == '0) ready_d[idx_q] = 1'b1;
        idx_d = idx_q + IdxW'(1);
        st_d = (idx_q == IdxW'(MaxNodes - 1)) ? StPick : StCpyR;
      end
      StPick: begin
        if (ready_q == '0) begin
          st_d = StFin;
        end else begin
          cur_d = low_bit(ready_q);
          ready_d[cur_d] = 1'b0;
          if (prev_v_q) begin
            valid_d = 1'b1; res_d.ok = 1'b1; res_d.node_valid = 1'b1;
            res_d.node_id = prev_q;
            res_d.node_total = ncnt_q; res_d.edge_total = ecnt_q;
          end
          prev_v_d = 1'b1; prev_d = cur_d;
          done_d = done_q + CntW'(1);
          st_d = StRowR;
        end
      end
      StRowR: begin
        adj_ra = cur_q; st_d = StRowW;
      end
      StRowW: begin
        row_d = adj_rd; st_d = StScan;
      end
      StScan: begin
        if (row_q == '0) begin
          st_d = StPick;
        end else begin
          deg_ra = nx; to_d = nx; row_d[nx] = 1'b0;
          st_d = StDecW;
        end
      end
      StDecW: begin
        if (wrk_cnt != '0) begin
          deg_we = 1'b1; deg_wa = to_q; deg_wd = {deg_cnt, dec};
          if (dec == '0 && CntW'(to_q) < ncnt_q) ready_d[to_q] = 1'b1;
        end
        st_d = StScan;
      end
      StFin: begin
        valid_d = 1'b1; res_d.ok = 1'b1; res_d.last = 1'b1;
        res_d.node_valid = prev_v_q;
        res_d.node_id = prev_v_q ? prev_q : '0;
        res_d.has_cycle = (done_q != ncnt_q);
        res_d.node_total = ncnt_q; res_d.edge_total = ecnt_q;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; idx_q <= '0; ncnt_q <= '0; ecnt_q <= '0;
      ready_q <= '0; done_q <= '0; prev_v_q <= 1'b0; valid_o <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; ncnt_q <= ncnt_d; ecnt_q <= ecnt_d;
      ready_q <= ready_d; done_q <= done_d; prev_v_q <= prev_v_d;
      valid_o <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    from_q <= from_d; to_q <= to_d; row_q <= row_d;
    prev_q <= prev_d; cur_q <= cur_d; res_o <= res_d;
  end

  // node count never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncnt_q <= CntW'(MaxNodes)) else $error("node count overflow");
  // a result never comes while the unit is idle for a cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy)) else $error("result without work");
  // node count only moves by one per step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ncnt_q != $past(ncnt_q)) |-> (ncnt_q == $past(ncnt_q) + CntW'(1)))
    else $error("node count jump");

endmodule
